@@ src/spwc_pkg.sv @@
package spwc_pkg;

    localparam int VW = 52;
    localparam int ZW = 34;
    localparam logic [ZW-1:0] QUARTER = ZW'(64'd1073741824);
    localparam logic [31:0] INV_GAIN = 32'd2608131496;
    localparam logic [13:0] FRAC_SCALE = 14'd10000;

    typedef enum logic [1:0] {
        REG_HALF_TRACK  = 2'd0,
        REG_DRIVE_GAIN  = 2'd1,
        REG_STEER_COUNT = 2'd2,
        REG_SPEED_LIMIT = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        CASE_ZERO  = 2'd0,
        CASE_YZERO = 2'd1,
        CASE_XZERO = 2'd2,
        CASE_ROT   = 2'd3
    } vec_case_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 folded;
        vec_case_t            kind;
    } vec_t;

    typedef struct packed {
        logic signed [15:0] rpm;
        logic signed [15:0] index;
        logic [13:0]        frac;
    } wheel_out_t;

    function automatic logic [31:0] atan_turns(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
            3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
            6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
            9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
            12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
            15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
            18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
            21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
            24: t = 32'd41;        25: t = 32'd20;        26: t = 32'd10;
            27: t = 32'd5;         28: t = 32'd3;         29: t = 32'd1;
            30: t = 32'd1;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

@@ src/spwc_if.sv @@
interface spwc_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] lin_x;
    logic signed [31:0] lin_y;
    logic signed [31:0] yaw_rate;
    modport source (output valid, lin_x, lin_y, yaw_rate, input ready);
    modport sink (input valid, lin_x, lin_y, yaw_rate, output ready);
endinterface

interface spwc_wheel_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] front_drive;
    logic signed [15:0] rear_drive;
    logic signed [15:0] front_pos;
    logic [13:0]        front_frac;
    logic signed [15:0] rear_pos;
    logic [13:0]        rear_frac;
    modport source (output valid, front_drive, rear_drive, front_pos, front_frac,
                    rear_pos, rear_frac, input ready);
    modport sink (input valid, front_drive, rear_drive, front_pos, front_frac,
                  rear_pos, rear_frac, output ready);
endinterface

@@ src/spwc_wheel.sv @@
module spwc_wheel #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          clk,
    input  logic                          adv,
    input  logic signed [spwc_pkg::VW-1:0] vx,
    input  logic signed [spwc_pkg::VW-1:0] vy,
    input  logic [31:0]                   drive_gain,
    input  logic [15:0]                   steer_counts,
    input  logic [31:0]                   speed_limit,
    output spwc_pkg::wheel_out_t          result
);
    import spwc_pkg::*;

    vec_t st_reg [CORDIC_STEPS+1];

    logic [VW-1:0]      mag_reg;
    logic signed [ZW-1:0] zc_reg;
    logic               fold_a_reg;
    logic [VW+15:0]     p_hi_reg;
    logic [47:0]        p_lo_reg;
    logic               fold_b_reg;
    logic signed [ZW-1:0] zb_reg;
    logic [31:0]        speed_reg;
    logic signed [49:0] pos_reg;
    logic               fold_c_reg;
    logic [63:0]        rprod_reg;
    logic signed [15:0] index_reg;
    logic [32:0]        rem_reg;
    logic               fold_d_reg;
    logic [46:0]        fprod_reg;
    logic signed [15:0] index_e_reg;
    logic signed [15:0] rpm_reg;

    vec_t entry;
    always_comb
    begin
        entry.folded = vx < 0;
        entry.x = entry.folded ? -vx : vx;
        entry.y = entry.folded ? -vy : vy;
        entry.z = '0;
        if (entry.x == 0 && entry.y == 0)
            entry.kind = CASE_ZERO;
        else if (entry.y == 0)
            entry.kind = CASE_YZERO;
        else if (entry.x == 0)
            entry.kind = CASE_XZERO;
        else
            entry.kind = CASE_ROT;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            st_reg[0] <= entry;
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_step
        vec_t nx;
        always_comb
        begin
            nx = st_reg[g];
            if (st_reg[g].kind == CASE_ROT && g < 32)
            begin
                if (st_reg[g].y >= 0)
                begin
                    nx.x = st_reg[g].x + (st_reg[g].y >>> g);
                    nx.y = st_reg[g].y - (st_reg[g].x >>> g);
                    nx.z = st_reg[g].z + ZW'(atan_turns(g));
                end
                else
                begin
                    nx.x = st_reg[g].x - (st_reg[g].y >>> g);
                    nx.y = st_reg[g].y + (st_reg[g].x >>> g);
                    nx.z = st_reg[g].z - ZW'(atan_turns(g));
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
                st_reg[g+1] <= nx;
        end
    end

    vec_t fin;
    logic [VW-1:0] ay;
    logic signed [ZW-1:0] zraw;
    assign fin = st_reg[CORDIC_STEPS];
    assign ay = fin.y < 0 ? VW'(-fin.y) : VW'(fin.y);
    always_comb
    begin
        zraw = fin.z;
        if (fin.kind == CASE_XZERO)
            zraw = fin.y > 0 ? $signed(QUARTER) : -$signed(QUARTER);
        else if (fin.kind != CASE_ROT)
            zraw = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            case (fin.kind)
                CASE_ZERO:  mag_reg <= '0;
                CASE_YZERO: mag_reg <= fin.x;
                CASE_XZERO: mag_reg <= ay;
                default:    mag_reg <= fin.x < 0 ? '0 : fin.x;
            endcase
            fold_a_reg <= fin.folded;
            if (zraw > $signed(QUARTER))
                zc_reg <= $signed(QUARTER);
            else if (zraw < -$signed(QUARTER))
                zc_reg <= -$signed(QUARTER);
            else
                zc_reg <= zraw;
        end
    end

    // magnitude path: rot results need 1/K scaling, others pass raw
    logic rot_a_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            rot_a_reg <= fin.kind == CASE_ROT;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_hi_reg   <= (VW+16)'(mag_reg[VW-1:16]) * (VW+16)'(INV_GAIN);
            p_lo_reg   <= 48'(mag_reg[15:0]) * 48'(INV_GAIN);
            fold_b_reg <= fold_a_reg;
            zb_reg     <= zc_reg;
        end
    end

    logic [VW-1:0] mag_b_reg;
    logic rot_b_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_b_reg <= mag_reg;
            rot_b_reg <= rot_a_reg;
        end
    end

    logic [VW+31:0] scaled;
    logic [VW-1:0]  mag_fin;
    assign scaled = (VW+32)'(p_hi_reg) + (VW+32)'(p_lo_reg >> 16);
    assign mag_fin = rot_b_reg ? VW'(scaled >> 16) : mag_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            speed_reg  <= mag_fin < VW'(speed_limit) ? mag_fin[31:0] : speed_limit;
            pos_reg    <= 50'(zb_reg) * $signed({1'b0, steer_counts});
            fold_c_reg <= fold_b_reg;
        end
    end

    logic [49:0] neg_p;
    assign neg_p = 50'(-pos_reg);
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rprod_reg  <= 64'(speed_reg) * 64'(drive_gain);
            fold_d_reg <= fold_c_reg;
            if (pos_reg >= 0)
            begin
                index_reg <= 16'(pos_reg >>> 32);
                rem_reg   <= {1'b0, pos_reg[31:0]};
            end
            else
            begin
                index_reg <= 16'(-$signed({1'b0, neg_p[49:32]}) - 1);
                rem_reg   <= 33'((33'(neg_p[49:32]) + 33'd1) << 32) - 33'(neg_p);
            end
        end
    end

    logic [31:0] rmag;
    assign rmag = rprod_reg[63:32];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fprod_reg   <= 47'(rem_reg) * 47'(FRAC_SCALE);
            index_e_reg <= index_reg;
            if (fold_d_reg)
                rpm_reg <= rmag > 32'd32768 ? -16'sd32768 : 16'(-$signed({1'b0, rmag}));
            else
                rpm_reg <= rmag > 32'd32767 ? 16'sd32767 : 16'(rmag);
        end
    end

    always_comb
    begin
        result.rpm   = rpm_reg;
        result.index = index_e_reg;
        result.frac  = fprod_reg[45:32];
    end

endmodule

@@ src/swerve_pair_wheel_command_unit.sv @@
// swerve pair wheel command unit
// in: spwc_cmd_if sink carrying lin_x, lin_y, yaw_rate (signed Q16.16)
// out: spwc_wheel_if source carrying rpm, steering index and fraction
//   for the front and rear wheel
// cfg: wr_en / wr_index / wr_data write port for the four registers
// one item is accepted per cycle while the pipeline advances; a result item
//   becomes valid once its input item has passed the input stage, the entry
//   stage, the cordic stage chain plus scaling and multiply stages
// the whole pipeline advances together; when the receiver stalls with a
//   valid item at the output the pipeline holds, and cmd.ready drops
// cmd.ready stays high while the output register is empty or taken
// reset clears all valid bits and loads the register defaults
// configuration must only change while the pipeline is empty
module swerve_pair_wheel_command_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    spwc_cmd_if.sink    cmd,
    spwc_wheel_if.source wheel,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [31:0] wr_data
);
    import spwc_pkg::*;

    localparam int DEPTH = CORDIC_STEPS + 7;

    logic [23:0] half_track_reg;
    logic [31:0] drive_gain_reg;
    logic [15:0] steer_reg;
    logic [31:0] speed_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_track_reg  <= 24'd44237;
            drive_gain_reg  <= 32'd15728640;
            steer_reg       <= 16'd350;
            speed_limit_reg <= 32'd32768000;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_HALF_TRACK:  half_track_reg  <= wr_data[23:0];
                REG_DRIVE_GAIN:  drive_gain_reg  <= wr_data;
                REG_STEER_COUNT: steer_reg       <= wr_data[15:0];
                REG_SPEED_LIMIT: speed_limit_reg <= wr_data;
                default: ;
            endcase
        end
    end

    logic [DEPTH-1:0] vld_reg;
    logic             adv;
    assign adv = !vld_reg[DEPTH-1] || wheel.ready;
    assign cmd.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], cmd.valid};
    end

    logic signed [VW-1:0] x0_reg, y0_reg, t_reg;
    logic signed [56:0]   prod;
    assign prod = 57'(cmd.yaw_rate) * $signed({1'b0, half_track_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_reg <= VW'(cmd.lin_x);
            y0_reg <= VW'(cmd.lin_y);
            t_reg  <= VW'(prod >>> 16);
        end
    end

    logic signed [VW-1:0] fy, ry;
    assign fy = y0_reg + t_reg;
    assign ry = y0_reg - t_reg;

    wheel_out_t fr, rr;

    spwc_wheel #(.CORDIC_STEPS(CORDIC_STEPS)) u_front (
        .clk, .adv, .vx(x0_reg), .vy(fy),
        .drive_gain(drive_gain_reg), .steer_counts(steer_reg),
        .speed_limit(speed_limit_reg), .result(fr)
    );

    spwc_wheel #(.CORDIC_STEPS(CORDIC_STEPS)) u_rear (
        .clk, .adv, .vx(x0_reg), .vy(ry),
        .drive_gain(drive_gain_reg), .steer_counts(steer_reg),
        .speed_limit(speed_limit_reg), .result(rr)
    );

    assign wheel.valid       = vld_reg[DEPTH-1];
    assign wheel.front_drive = fr.rpm;
    assign wheel.front_pos   = fr.index;
    assign wheel.front_frac  = fr.frac;
    assign wheel.rear_drive  = rr.rpm;
    assign wheel.rear_pos    = rr.index;
    assign wheel.rear_frac   = rr.frac;

endmodule
